[hw/rtl/vlm_pkg.sv]
// vlm_pkg: shared types and constants for the volume local maximum test.
// No dependencies; imported by the top level, vlm_cfg and vlm_scan.
package vlm_pkg;

  localparam int POS_W       = 5;   // coordinate field width
  localparam int SIZE_W      = 6;   // size register width
  localparam int RAD_W       = 5;   // radius register width
  localparam int IN_SAMPLE_W = 16;  // sample field width on the input
  localparam int CRD_W       = 6;   // internal coordinate width (pos + radius fits)
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_RADIUS
  } reg_idx_t;

  // Saturated extents and radius, as the sequencer uses them
  typedef struct packed {
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    logic [SIZE_W-1:0] nz;
    logic [RAD_W-1:0]  radius;
  } vol_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_CENTRE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } seq_state_t;

  // What the read data coming back this cycle belongs to
  typedef enum logic [1:0] {
    RD_CENTRE,
    RD_NEIGH,
    RD_SKIP
  } rd_kind_t;

endpackage

[hw/rtl/volume_local_maximum_test.sv]
// volume_local_maximum_test: top level of the 3D local maximum test.
// Depends on vlm_pkg, vlm_cfg, vlm_scan and vlm_ram.
//
// The block stores a volume of signed samples, addressed x + MAX_SIZE_X*(y +
// MAX_SIZE_Y*z), in one RAM with a registered read. It works on one input
// transaction at a time. A write (tuser 0) stores its sample; an
// out-of-volume write is ignored. A query (tuser 1) reads the centre, then every
// position of the window clipped to the volume, one RAM read per cycle, and
// ends the scan early when a neighbour at or above the centre is found. A
// query outside the volume returns position_invalid with no RAM access. The
// result waits in an output register while the next item is taken. Voxels
// must be written before they are queried; the memory has no reset and no
// clearing pass.
module volume_local_maximum_test import vlm_pkg::*; #(
  parameter int MAX_SIZE_X  = 32,
  parameter int MAX_SIZE_Y  = 32,
  parameter int MAX_SIZE_Z  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // pos_x[4:0] pos_y[9:5] pos_z[14:10] sample[30:15]
  input  logic                  in_tuser,   // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // is_local_max[0]
  output logic                  out_tuser   // position_invalid
);

  localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vol_cfg_t               cfg;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  logic                   is_local_max;

  assign cfg_ready = 1'b1;

  vlm_cfg #(
    .MAX_SIZE_X(MAX_SIZE_X),
    .MAX_SIZE_Y(MAX_SIZE_Y),
    .MAX_SIZE_Z(MAX_SIZE_Z)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vlm_scan #(
    .MAX_SIZE_X (MAX_SIZE_X),
    .MAX_SIZE_Y (MAX_SIZE_Y),
    .MAX_SIZE_Z (MAX_SIZE_Z),
    .SAMPLE_BITS(SAMPLE_BITS),
    .AW         (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_x      (in_tdata[4:0]),
    .in_y      (in_tdata[9:5]),
    .in_z      (in_tdata[14:10]),
    .in_sample ($signed(in_tdata[30:15])),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_max   (is_local_max),
    .out_inv   (out_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  vlm_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_voxels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {7'b0, is_local_max};

endmodule

[hw/rtl/vlm_ram.sv]
// vlm_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
module vlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/vlm_cfg.sv]
// vlm_cfg: configuration registers and extent saturation.
// Depends on vlm_pkg.
module vlm_cfg import vlm_pkg::*; #(
  parameter int MAX_SIZE_X = 32,
  parameter int MAX_SIZE_Y = 32,
  parameter int MAX_SIZE_Z = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output vol_cfg_t              cfg
);

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [RAD_W-1:0]  radius_r;

  // extent clamps the register to 1..max of its axis
  function automatic logic [SIZE_W-1:0] extent(input logic [SIZE_W-1:0] v, input int maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(32);
      size_y_r <= SIZE_W'(32);
      size_z_r <= SIZE_W'(32);
      radius_r <= RAD_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_SIZE_X: size_x_r <= wr_data[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= wr_data[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= wr_data[SIZE_W-1:0];
        REG_RADIUS: radius_r <= wr_data[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    cfg.nx     = extent(size_x_r, MAX_SIZE_X);
    cfg.ny     = extent(size_y_r, MAX_SIZE_Y);
    cfg.nz     = extent(size_z_r, MAX_SIZE_Z);
    cfg.radius = radius_r;
  end

endmodule

[hw/rtl/vlm_scan.sv]
// vlm_scan: item sequencer. Stores voxels, walks the query window one read
// per cycle through the voxel RAM and holds the result register.
// Depends on vlm_pkg; drives the ports of one vlm_ram.
module vlm_scan import vlm_pkg::*; #(
  parameter int MAX_SIZE_X  = 32,
  parameter int MAX_SIZE_Y  = 32,
  parameter int MAX_SIZE_Z  = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vol_cfg_t                     cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [POS_W-1:0]             in_x,
  input  logic [POS_W-1:0]             in_y,
  input  logic [POS_W-1:0]             in_z,
  input  logic signed [IN_SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_max,
  output logic                         out_inv,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [SAMPLE_BITS-1:0]       ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  logic [SAMPLE_BITS-1:0]       ram_rdata
);

  seq_state_t state_r, state_nxt;

  logic [CRD_W-1:0] x0_r, y0_r, z0_r;
  logic [CRD_W-1:0] x0_nxt, y0_nxt, z0_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [CRD_W-1:0] xlo_r, xhi_r, ylo_r, yhi_r, zlo_r, zhi_r;
  logic [CRD_W-1:0] xlo_nxt, xhi_nxt, ylo_nxt, yhi_nxt, zlo_nxt, zhi_nxt;
  logic [CRD_W-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  rd_kind_t         rd_kind_r, rd_kind_nxt;
  logic signed [SAMPLE_BITS-1:0] centre_r, centre_nxt;
  logic             peak_r, peak_nxt;
  logic             inv_r, inv_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_max_r, out_max_nxt;
  logic             out_inv_r, out_inv_nxt;

  logic             accept, in_vol, last, hit;
  logic [CRD_W-1:0] rx, ry, rz;

  function automatic logic [AW-1:0] addr_of(input logic [CRD_W-1:0] x,
                                            input logic [CRD_W-1:0] y,
                                            input logic [CRD_W-1:0] z);
    return AW'(x) + AW'(MAX_SIZE_X) * (AW'(y) + AW'(MAX_SIZE_Y) * AW'(z));
  endfunction

  function automatic logic [CRD_W-1:0] lo_of(input logic [CRD_W-1:0] c,
                                             input logic [RAD_W-1:0] r);
    return (c < CRD_W'(r)) ? '0 : c - CRD_W'(r);
  endfunction

  function automatic logic [CRD_W-1:0] hi_of(input logic [CRD_W-1:0] c,
                                             input logic [RAD_W-1:0] r,
                                             input logic [SIZE_W-1:0] n);
    logic [CRD_W-1:0] s;
    s = c + CRD_W'(r);
    return (s >= CRD_W'(n)) ? CRD_W'(n) - CRD_W'(1) : s;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_vol   = ({1'b0, in_x} < cfg.nx) && ({1'b0, in_y} < cfg.ny) &&
                    ({1'b0, in_z} < cfg.nz);
  assign last     = (cx_r == xhi_r) && (cy_r == yhi_r) && (cz_r == zhi_r);
  // returned neighbour at or above the centre defeats the peak
  assign hit      = rd_pend_r && (rd_kind_r == RD_NEIGH) &&
                    ($signed(ram_rdata) >= centre_r);

  always_comb begin
    rx = (state_r == S_CENTRE) ? x0_r : cx_r;
    ry = (state_r == S_CENTRE) ? y0_r : cy_r;
    rz = (state_r == S_CENTRE) ? z0_r : cz_r;
  end

  assign ram_we    = (state_r == S_WRITE);
  assign ram_waddr = addr_of(x0_r, y0_r, z0_r);
  assign ram_wdata = sample_r;
  assign ram_re    = (state_r == S_CENTRE) || (state_r == S_SCAN);
  assign ram_raddr = addr_of(rx, ry, rz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    z0_r      <= z0_nxt;
    sample_r  <= sample_nxt;
    xlo_r     <= xlo_nxt;
    xhi_r     <= xhi_nxt;
    ylo_r     <= ylo_nxt;
    yhi_r     <= yhi_nxt;
    zlo_r     <= zlo_nxt;
    zhi_r     <= zhi_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cz_r      <= cz_nxt;
    rd_kind_r <= rd_kind_nxt;
    centre_r  <= centre_nxt;
    peak_r    <= peak_nxt;
    inv_r     <= inv_nxt;
    out_max_r <= out_max_nxt;
    out_inv_r <= out_inv_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    z0_nxt        = z0_r;
    sample_nxt    = sample_r;
    xlo_nxt       = xlo_r;
    xhi_nxt       = xhi_r;
    ylo_nxt       = ylo_r;
    yhi_nxt       = yhi_r;
    zlo_nxt       = zlo_r;
    zhi_nxt       = zhi_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    rd_pend_nxt   = 1'b0;
    rd_kind_nxt   = rd_kind_r;
    centre_nxt    = centre_r;
    peak_nxt      = peak_r;
    inv_nxt       = inv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_max_nxt   = out_max_r;
    out_inv_nxt   = out_inv_r;

    // returned read data, consumed while scanning or draining
    if (rd_pend_r && (rd_kind_r == RD_CENTRE)) begin
      centre_nxt = $signed(ram_rdata);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x0_nxt     = CRD_W'(in_x);
          y0_nxt     = CRD_W'(in_y);
          z0_nxt     = CRD_W'(in_z);
          sample_nxt = SAMPLE_BITS'(in_sample);
          peak_nxt   = 1'b1;
          inv_nxt    = 1'b0;
          if (in_op == OP_WRITE) begin
            state_nxt = in_vol ? S_WRITE : S_IDLE;
          end else if (in_vol) begin
            state_nxt = S_CENTRE;
          end else begin
            peak_nxt  = 1'b0;
            inv_nxt   = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      S_CENTRE: begin
        xlo_nxt     = lo_of(x0_r, cfg.radius);
        ylo_nxt     = lo_of(y0_r, cfg.radius);
        zlo_nxt     = lo_of(z0_r, cfg.radius);
        xhi_nxt     = hi_of(x0_r, cfg.radius, cfg.nx);
        yhi_nxt     = hi_of(y0_r, cfg.radius, cfg.ny);
        zhi_nxt     = hi_of(z0_r, cfg.radius, cfg.nz);
        cx_nxt      = xlo_nxt;
        cy_nxt      = ylo_nxt;
        cz_nxt      = zlo_nxt;
        rd_pend_nxt = 1'b1;
        rd_kind_nxt = RD_CENTRE;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          peak_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          rd_pend_nxt = 1'b1;
          rd_kind_nxt = ((cx_r == x0_r) && (cy_r == y0_r) && (cz_r == z0_r)) ?
                        RD_SKIP : RD_NEIGH;
          if (last) begin
            state_nxt = S_DRAIN;
          end else if (cx_r != xhi_r) begin
            cx_nxt = cx_r + CRD_W'(1);
          end else begin
            cx_nxt = xlo_r;
            if (cy_r != yhi_r) begin
              cy_nxt = cy_r + CRD_W'(1);
            end else begin
              cy_nxt = ylo_r;
              cz_nxt = cz_r + CRD_W'(1);
            end
          end
        end
      end
      S_DRAIN: begin
        if (hit) begin
          peak_nxt = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = peak_r;
          out_inv_nxt   = inv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_max   = out_max_r;
  assign out_inv   = out_inv_r;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("voxel write and read in the same cycle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done state");

  a_inv_not_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> !out_max_r)
    else $error("invalid position reported as local maximum");

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cx_r >= xlo_r) && (cx_r <= xhi_r) &&
                            (cy_r >= ylo_r) && (cy_r <= yhi_r) &&
                            (cz_r >= zlo_r) && (cz_r <= zhi_r))
    else $error("scan coordinate outside the clipped window");

endmodule

[tb/volume_local_maximum_test_test.sv]
// Self-checking bench for volume_local_maximum_test: writes voxels, queries strict 3D peaks
// and checks each answer against a behavioral peak tracker. Depends on vlm_pkg and the RTL.
// Runs directed items, then random phases over several volume sizes and radii.
module volume_local_maximum_test_test;
  import vlm_pkg::*;

  localparam int EDGE           = 32;              // MAX_SIZE_* of the block, all axes
  localparam int VOL_DEPTH      = EDGE * EDGE * EDGE;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 250;

  typedef struct packed {
    logic peak;
    logic invalid;
  } verdict_t;

  // Tracks the stored volume and registers, predicts one verdict per query
  class peak_tracker;
    logic signed [IN_SAMPLE_W-1:0] voxels [VOL_DEPTH];
    logic [SIZE_W-1:0]             size_reg [3];
    logic [RAD_W-1:0]              radius_reg;
    verdict_t                      awaited_verdicts [$];
    int                            mismatches;

    function new();
      for (int a = 0; a < 3; a++) size_reg[a] = EDGE;
      radius_reg = 1;
      mismatches = 0;
      foreach (voxels[i]) voxels[i] = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SIZE_X: size_reg[0] = v;
        REG_SIZE_Y: size_reg[1] = v;
        REG_SIZE_Z: size_reg[2] = v;
        REG_RADIUS: radius_reg = v[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // extent in use: register saturated to 1..EDGE
    function int span(int axis);
      if (size_reg[axis] == 0) return 1;
      if (size_reg[axis] > EDGE) return EDGE;
      return size_reg[axis];
    endfunction

    function int addr(int x, int y, int z);
      return x + EDGE * (y + EDGE * z);
    endfunction

    function void take_item(logic op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                            logic [POS_W-1:0] pz, logic signed [IN_SAMPLE_W-1:0] s);
      int c [3];
      int lo [3];
      int hi [3];
      int r;
      bit in_vol;
      logic signed [IN_SAMPLE_W-1:0] centre;
      verdict_t v;
      c[0] = px;
      c[1] = py;
      c[2] = pz;
      r = radius_reg;
      in_vol = 1;
      for (int a = 0; a < 3; a++) if (c[a] >= span(a)) in_vol = 0;
      if (op == OP_WRITE) begin
        if (in_vol) voxels[addr(c[0], c[1], c[2])] = s;
        return;
      end
      v.peak = 1'b0;
      v.invalid = !in_vol;
      if (in_vol) begin
        centre = voxels[addr(c[0], c[1], c[2])];
        v.peak = 1'b1;
        for (int a = 0; a < 3; a++) begin
          lo[a] = (c[a] < r) ? 0 : c[a] - r;
          hi[a] = (c[a] + r >= span(a)) ? span(a) - 1 : c[a] + r;
        end
        for (int z = lo[2]; z <= hi[2]; z++)
          for (int y = lo[1]; y <= hi[1]; y++)
            for (int x = lo[0]; x <= hi[0]; x++)
              if (!(x == c[0] && y == c[1] && z == c[2]) && voxels[addr(x, y, z)] >= centre)
                v.peak = 1'b0;
      end
      awaited_verdicts.push_back(v);
    endfunction

    function void check_answer(logic peak, logic invalid);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected result is_local_max=%0b position_invalid=%0b",
                 $time, peak, invalid);
        mismatches++;
        return;
      end
      want = awaited_verdicts.pop_front();
      if (peak !== want.peak) begin
        $display("%0t: is_local_max expected %0b actual %0b", $time, want.peak, peak);
        mismatches++;
      end
      if (invalid !== want.invalid) begin
        $display("%0t: position_invalid expected %0b actual %0b", $time, want.invalid, invalid);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  out_tuser;

  peak_tracker tracker = new();

  bit tx_steady       = 0;
  bit rx_steady       = 0;
  int hold_cycles_req = 0;
  int idle_cycles     = 0;

  volume_local_maximum_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // transaction monitor: feeds the tracker on every handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready)
        tracker.take_item(in_tuser, in_tdata[4:0], in_tdata[9:5], in_tdata[14:10],
                          in_tdata[30:15]);
      if (out_tvalid && out_tready) tracker.check_answer(out_tdata[0], out_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result sink: random stalls, steady stretches, and a long hold-off on request
  initial begin
    int run;
    int hold_left;
    int roll;
    bit on;
    run = 0;
    hold_left = 0;
    roll = 0;
    on = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        hold_left = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (rx_steady) begin
        out_tready = 1'b1;
      end else begin
        if (run == 0) begin
          roll = $urandom_range(0, 19);
          if (roll < 10) begin
            on = 1'b1;
            run = $urandom_range(1, 20);
          end else if (roll < 17) begin
            on = 1'b0;
            run = $urandom_range(1, 3);
          end else begin
            on = 1'b0;
            run = $urandom_range(10, 40);
          end
        end
        run--;
        out_tready = on;
      end
    end
  end

  function automatic int pick_gap();
    int k;
    if (tx_steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_SAMPLE_W-1:0] pick_sample(bit narrow);
    int v;
    if (narrow) v = $urandom_range(0, 6) - 3;
    else v = $urandom_range(0, 65535);
    return v[IN_SAMPLE_W-1:0];
  endfunction

  task automatic send_item(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           logic [POS_W-1:0] z, logic [IN_SAMPLE_W-1:0] s);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {1'b0, s, z, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop offering, wait for every awaited verdict, then let trailing writes finish
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.awaited_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int sx, int sy, int sz, int r);
    settle();
    write_reg(REG_SIZE_X, sx[CFG_DATA_W-1:0]);
    write_reg(REG_SIZE_Y, sy[CFG_DATA_W-1:0]);
    write_reg(REG_SIZE_Z, sz[CFG_DATA_W-1:0]);
    write_reg(REG_RADIUS, r[CFG_DATA_W-1:0]);
  endtask

  // fill the whole volume in use, so any in-volume query reads only written voxels
  task automatic run_phase(int sx, int sy, int sz, int r, int n, bit narrow, bit hold);
    int k;
    configure(sx, sy, sz, r);
    for (int z = 0; z < tracker.span(2); z++)
      for (int y = 0; y < tracker.span(1); y++)
        for (int x = 0; x < tracker.span(0); x++)
          send_item(OP_WRITE, x[POS_W-1:0], y[POS_W-1:0], z[POS_W-1:0], pick_sample(narrow));
    if (hold) hold_cycles_req = HOLD_CYCLES;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55)
        send_item(OP_QUERY, $urandom_range(0, tracker.span(0) - 1),
                  $urandom_range(0, tracker.span(1) - 1),
                  $urandom_range(0, tracker.span(2) - 1), pick_sample(0));
      else if (k < 80)
        send_item(OP_WRITE, $urandom_range(0, tracker.span(0) - 1),
                  $urandom_range(0, tracker.span(1) - 1),
                  $urandom_range(0, tracker.span(2) - 1), pick_sample(narrow));
      else if (k < 90)
        send_item(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), pick_sample(narrow));
      else
        send_item(OP_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 31), pick_sample(0));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SIZE_X;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_WRITE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: sample extremes, tie with a neighbour, out-of-volume write and query
    configure(2, 2, 1, 1);
    send_item(OP_WRITE, 0, 0, 0, 16'h7fff);
    send_item(OP_WRITE, 1, 0, 0, 16'h8000);
    send_item(OP_WRITE, 0, 1, 0, 16'h0000);
    send_item(OP_WRITE, 1, 1, 0, 16'h7fff);
    send_item(OP_QUERY, 0, 0, 0, 16'h0000);
    send_item(OP_QUERY, 1, 0, 0, 16'h0000);
    send_item(OP_QUERY, 0, 1, 0, 16'hffff);
    send_item(OP_WRITE, 1, 1, 0, 16'hffff);
    send_item(OP_QUERY, 0, 0, 0, 16'h0000);
    send_item(OP_WRITE, 31, 31, 31, 16'h5555);
    send_item(OP_QUERY, 31, 31, 31, 16'haaaa);
    send_item(OP_QUERY, 2, 0, 0, 16'h0000);
    send_item(OP_QUERY, 0, 0, 1, 16'h0000);
    // radius 0: no neighbours at all
    configure(2, 2, 1, 0);
    send_item(OP_QUERY, 1, 0, 0, 16'h0000);
    send_item(OP_QUERY, 1, 1, 0, 16'h0000);

    run_phase(3, 3, 3, 1, 40, 1, 0);
    run_phase(4, 4, 2, 2, 30, 1, 0);
    run_phase(32, 1, 1, 31, 20, 0, 0);
    run_phase(0, 63, 1, 3, 20, 1, 0);     // size 0 acts as 1, 63 saturates
    run_phase(1, 1, 32, 0, 15, 0, 0);
    run_phase(5, 3, 2, 1, 50, 1, 1);      // sink holds off while items keep coming
    run_phase(1, 1, 1, 2, 10, 0, 0);      // single voxel: never a neighbour
    tx_steady = 1;
    rx_steady = 1;
    run_phase(2, 3, 4, 1, 40, 1, 0);
    tx_steady = 0;
    rx_steady = 0;

    settle();
    if (tracker.mismatches == 0 && tracker.awaited_verdicts.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
